// ===== rtl/core/bes_pkg.sv =====
// bes_pkg: shared types, constants and lookup functions for the buzzer effect sequencer
// depends on nothing; used by the interfaces and every module in rtl/core
`default_nettype none

package bes_pkg;

  // timer clock and prescaler
  localparam int unsigned ClkHz      = 170000000;
  localparam int unsigned PscDiv     = 50;
  localparam int unsigned PauseCount = 100;

  // field widths
  localparam int unsigned EffectW  = 4;
  localparam int unsigned ToneW    = 5;
  localparam int unsigned MsW      = 10;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned PollW    = 10;
  localparam int unsigned ReloadW  = 14;
  localparam int unsigned CompareW = 13;

  typedef logic [EffectW-1:0]  effect_t;
  typedef logic [ToneW-1:0]    tone_t;
  typedef logic [MsW-1:0]      ms_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [PollW-1:0]    poll_t;
  typedef logic [ReloadW-1:0]  reload_t;
  typedef logic [CompareW-1:0] compare_t;

  // input actions
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // effect codes
  localparam effect_t EFF_OFF      = 4'd0;
  localparam effect_t EFF_START    = 4'd1;
  localparam effect_t EFF_CAP_ON   = 4'd2;
  localparam effect_t EFF_CAP_OFF  = 4'd3;
  localparam effect_t EFF_AIM_ON   = 4'd4;
  localparam effect_t EFF_AIM_OFF  = 4'd5;
  localparam effect_t EFF_SHOOT1   = 4'd6;
  localparam effect_t EFF_SHOOT8   = 4'd13;

  // tone codes
  localparam tone_t TONE_P  = 5'd0;
  localparam tone_t TONE_M1 = 5'd8;
  localparam tone_t TONE_M2 = 5'd9;
  localparam tone_t TONE_M3 = 5'd10;
  localparam tone_t TONE_M5 = 5'd12;
  localparam tone_t TONE_M6 = 5'd13;
  localparam tone_t TONE_M7 = 5'd14;

  // reset value of the poll interval
  localparam poll_t POLL_RESET = 10'd10;

  typedef struct packed {
    logic  valid;
    tone_t tone;
    ms_t   ms;
  } note_t;

  typedef struct packed {
    logic     pwm_on;
    reload_t  reload_value;
    compare_t compare_value;
    tone_t    tone_now;
    logic     playing;
  } res_t;

  function automatic note_t mk_note(tone_t t, int unsigned ms);
    note_t n;
    n.valid = 1'b1;
    n.tone  = t;
    n.ms    = ms_t'(ms);
    return n;
  endfunction

  // timer period count for a tone, 3400000 / f
  function automatic reload_t period_count(tone_t t);
    reload_t c;
    case (t)
      5'd1:    c = reload_t'(ClkHz / PscDiv / 262);
      5'd2:    c = reload_t'(ClkHz / PscDiv / 294);
      5'd3:    c = reload_t'(ClkHz / PscDiv / 330);
      5'd4:    c = reload_t'(ClkHz / PscDiv / 349);
      5'd5:    c = reload_t'(ClkHz / PscDiv / 392);
      5'd6:    c = reload_t'(ClkHz / PscDiv / 440);
      5'd7:    c = reload_t'(ClkHz / PscDiv / 494);
      5'd8:    c = reload_t'(ClkHz / PscDiv / 523);
      5'd9:    c = reload_t'(ClkHz / PscDiv / 587);
      5'd10:   c = reload_t'(ClkHz / PscDiv / 659);
      5'd11:   c = reload_t'(ClkHz / PscDiv / 698);
      5'd12:   c = reload_t'(ClkHz / PscDiv / 784);
      5'd13:   c = reload_t'(ClkHz / PscDiv / 880);
      5'd14:   c = reload_t'(ClkHz / PscDiv / 988);
      5'd15:   c = reload_t'(ClkHz / PscDiv / 1046);
      5'd16:   c = reload_t'(ClkHz / PscDiv / 1175);
      5'd17:   c = reload_t'(ClkHz / PscDiv / 1318);
      5'd18:   c = reload_t'(ClkHz / PscDiv / 1397);
      5'd19:   c = reload_t'(ClkHz / PscDiv / 1568);
      5'd20:   c = reload_t'(ClkHz / PscDiv / 1760);
      5'd21:   c = reload_t'(ClkHz / PscDiv / 1976);
      default: c = reload_t'(PauseCount);
    endcase
    return c;
  endfunction

  // note idx of an effect; valid low past the end or for an unknown code
  function automatic note_t effect_note(effect_t eff, idx_t idx);
    note_t n;
    idx_t  shot_len;
    n        = '0;
    shot_len = {effect_t'(eff - 4'd5), 1'b0};
    case (eff)
      EFF_START: begin
        case (idx)
          5'd0:    n = mk_note(TONE_M1, 200);
          5'd1:    n = mk_note(TONE_P, 50);
          5'd2:    n = mk_note(TONE_M2, 200);
          5'd3:    n = mk_note(TONE_P, 50);
          5'd4:    n = mk_note(TONE_M3, 200);
          5'd5:    n = mk_note(TONE_P, 50);
          5'd6:    n = mk_note(TONE_M2, 200);
          5'd7:    n = mk_note(TONE_P, 50);
          5'd8:    n = mk_note(TONE_M5, 200);
          5'd9:    n = mk_note(TONE_P, 50);
          5'd10:   n = mk_note(TONE_M7, 200);
          5'd11:   n = mk_note(TONE_P, 50);
          5'd12:   n = mk_note(TONE_M6, 500);
          5'd13:   n = mk_note(TONE_M5, 250);
          5'd14:   n = mk_note(TONE_M6, 750);
          default: n = '0;
        endcase
      end
      EFF_CAP_ON: begin
        case (idx)
          5'd0:    n = mk_note(TONE_M1, 200);
          5'd1:    n = mk_note(TONE_M3, 200);
          5'd2:    n = mk_note(TONE_M5, 200);
          default: n = '0;
        endcase
      end
      EFF_CAP_OFF: begin
        case (idx)
          5'd0:    n = mk_note(TONE_M5, 200);
          5'd1:    n = mk_note(TONE_M3, 200);
          5'd2:    n = mk_note(TONE_M1, 200);
          default: n = '0;
        endcase
      end
      EFF_AIM_ON: begin
        case (idx)
          5'd0, 5'd2, 5'd4: n = mk_note(TONE_M7, 50);
          5'd1, 5'd3, 5'd5: n = mk_note(TONE_P, 150);
          default:          n = '0;
        endcase
      end
      EFF_AIM_OFF: begin
        case (idx)
          5'd0:    n = mk_note(TONE_M7, 200);
          5'd1:    n = mk_note(TONE_M5, 200);
          5'd2:    n = mk_note(TONE_M3, 200);
          default: n = '0;
        endcase
      end
      default: begin
        // shots: note then pause, 100 ms each
        if (eff >= EFF_SHOOT1 && eff <= EFF_SHOOT8 && idx < shot_len) begin
          n = mk_note(idx[0] ? TONE_P : TONE_M5, 100);
        end
      end
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bes_if.sv =====
// bes_in_if and bes_out_if: valid/ready channels of the buzzer effect sequencer
// depends on bes_pkg
`default_nettype none

interface bes_in_if;
  import bes_pkg::*;
  logic    valid;
  logic    ready;
  logic    action;
  effect_t effect;

  modport source (output valid, output action, output effect, input ready);
  modport sink   (input valid, input action, input effect, output ready);
endinterface

interface bes_out_if;
  import bes_pkg::*;
  logic     valid;
  logic     ready;
  logic     pwm_on;
  reload_t  reload_value;
  compare_t compare_value;
  tone_t    tone_now;
  logic     playing;

  modport source (output valid, output pwm_on, output reload_value, output compare_value,
                  output tone_now, output playing, input ready);
  modport sink   (input valid, input pwm_on, input reload_value, input compare_value,
                  input tone_now, input playing, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/buzzer_effect_sequencer_top.sv =====
// buzzer_effect_sequencer_top: buzzer effect sequencer, ticks and requests in, timer settings out
// depends on bes_pkg, bes_if, bes_seq and bes_out
//
//   channel   direction  handshake        payload
//   in_ch     in         valid / ready    action, effect
//   out_ch    out        valid / ready    pwm_on, reload_value, compare_value, tone_now, playing
//   cfg       in         cfg_we           cfg_wdata (poll_ms)
//
// one transaction accepted per cycle while in_ch ready is high; its result is registered in the result buffer
// the state update and note/period lookup sit in one stage ahead of the result buffer
// a two-entry result buffer holds results while out_ch stalls; in_ch ready drops only when full
// reset clears the sequencer state and sets poll_ms to 10
`default_nettype none

module buzzer_effect_sequencer_top
  import bes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  bes_in_if.sink     in_ch,
  bes_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire poll_t cfg_wdata
);

  res_t seq_res;
  res_t buf_res;
  logic accept;
  logic push_ready;

  assign accept      = in_ch.valid && push_ready;
  assign in_ch.ready = push_ready;

  // sequencer state and lookups
  bes_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (in_ch.action),
    .effect    (in_ch.effect),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (seq_res)
  );

  // result buffer
  bes_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_res   (seq_res),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (buf_res)
  );

  assign out_ch.pwm_on        = buf_res.pwm_on;
  assign out_ch.reload_value  = buf_res.reload_value;
  assign out_ch.compare_value = buf_res.compare_value;
  assign out_ch.tone_now      = buf_res.tone_now;
  assign out_ch.playing       = buf_res.playing;

endmodule

`default_nettype wire

// ===== rtl/core/bes_seq.sv =====
// bes_seq: sequencer state, poll counter, note lookup and timer settings for each transaction
// depends on bes_pkg
`default_nettype none

module bes_seq
  import bes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire logic  action,
  input  wire effect_t effect,
  input  wire logic  cfg_we,
  input  wire poll_t cfg_wdata,
  output res_t       res
);

  poll_t   poll_ms;
  effect_t pending_effect, pending_effect_next;
  effect_t active_effect, active_effect_next;
  idx_t    step_index, step_index_next;
  ms_t     step_ms_left, step_ms_left_next;
  poll_t   poll_count, poll_count_next;
  tone_t   current_tone, current_tone_next;
  logic    pwm_running, pwm_running_next;
  logic    in_sequence, in_sequence_next;

  note_t   step_note;
  note_t   start_note;
  idx_t    step_index_inc;
  ms_t     ms_dec;
  logic    poll_due;
  reload_t cnt;

  // note lookups for the next step and for a poll start
  assign step_index_inc = idx_t'(step_index + 5'd1);
  assign step_note      = effect_note(active_effect, step_index_inc);
  assign start_note     = effect_note(pending_effect, 5'd0);
  assign ms_dec         = (step_ms_left != '0) ? ms_t'(step_ms_left - 10'd1) : '0;
  assign poll_due       = ({1'b0, poll_count} + 11'd1) >= {1'b0, poll_ms};

  // next state for an accepted transaction
  always_comb begin
    pending_effect_next = pending_effect;
    active_effect_next  = active_effect;
    step_index_next     = step_index;
    step_ms_left_next   = step_ms_left;
    poll_count_next     = poll_count;
    current_tone_next   = current_tone;
    pwm_running_next    = pwm_running;
    in_sequence_next    = in_sequence;
    if (action == ACT_REQUEST) begin
      if (!in_sequence) begin
        pending_effect_next = effect;
      end
    end else if (in_sequence) begin
      step_ms_left_next = ms_dec;
      if (ms_dec == '0) begin
        step_index_next = step_index_inc;
        if (step_note.valid) begin
          current_tone_next = step_note.tone;
          step_ms_left_next = step_note.ms;
        end else begin
          in_sequence_next    = 1'b0;
          pending_effect_next = EFF_OFF;
          poll_count_next     = '0;
        end
      end
    end else if (poll_due) begin
      poll_count_next = '0;
      if (pending_effect == EFF_OFF) begin
        current_tone_next = TONE_P;
        pwm_running_next  = 1'b0;
      end else if (start_note.valid) begin
        active_effect_next = pending_effect;
        step_index_next    = '0;
        current_tone_next  = start_note.tone;
        step_ms_left_next  = start_note.ms;
        pwm_running_next   = 1'b1;
        in_sequence_next   = 1'b1;
      end
    end else begin
      poll_count_next = poll_t'(poll_count + 10'd1);
    end
  end

  // timer settings from the new tone
  assign cnt               = period_count(current_tone_next);
  assign res.pwm_on        = pwm_running_next;
  assign res.reload_value  = reload_t'(cnt - 14'd1);
  assign res.compare_value = compare_t'(cnt >> 1);
  assign res.tone_now      = current_tone_next;
  assign res.playing       = in_sequence_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_ms        <= POLL_RESET;
      pending_effect <= EFF_OFF;
      active_effect  <= EFF_OFF;
      step_index     <= '0;
      step_ms_left   <= '0;
      poll_count     <= '0;
      current_tone   <= TONE_P;
      pwm_running    <= 1'b0;
      in_sequence    <= 1'b0;
    end else begin
      if (cfg_we) begin
        poll_ms <= cfg_wdata;
      end
      if (accept) begin
        pending_effect <= pending_effect_next;
        active_effect  <= active_effect_next;
        step_index     <= step_index_next;
        step_ms_left   <= step_ms_left_next;
        poll_count     <= poll_count_next;
        current_tone   <= current_tone_next;
        pwm_running    <= pwm_running_next;
        in_sequence    <= in_sequence_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bes_out.sv =====
// bes_out: two-entry result buffer (output register plus skid stage)
// depends on bes_pkg
`default_nettype none

module bes_out
  import bes_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_res,
  output logic      push_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic main_valid;
  res_t main_res;
  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_res    = main_res;
  assign pop        = main_valid && out_ready;

  // control: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (push) begin
        main_res <= push_res;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_res <= push_res;
      end else begin
        main_res <= push_res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_buzzer_effect_sequencer_top.sv =====
// tb_buzzer_effect_sequencer_top: self-checking bench for the buzzer effect sequencer
// drives tick and request transactions, predicts every timer setting and compares it
// depends on bes_pkg, bes_if and buzzer_effect_sequencer_top
`timescale 1ns / 100ps

module tb_buzzer_effect_sequencer_top;
  import bes_pkg::*;

  // timer clock after the prescaler, and the tone table
  localparam int unsigned TIMER_HZ     = 3_400_000;
  localparam int unsigned PAUSE_PERIOD = 100;
  localparam int unsigned TONE_TOP     = 21;
  localparam int unsigned NOTE_HZ [0:21] = '{
    0, 262, 294, 330, 349, 392, 440, 494,
    523, 587, 659, 698, 784, 880, 988,
    1046, 1175, 1318, 1397, 1568, 1760, 1976
  };

  // codes past the last shot are not effects
  localparam effect_t EFF_UNKNOWN_LO = EFF_SHOOT8 + 4'd1;
  localparam effect_t EFF_UNKNOWN_HI = 4'hf;

  // longest run of ticks in one episode, keeps the whole run near its item budget
  localparam int EPISODE_MAX = 300;

  typedef struct {
    logic    action;
    effect_t effect;
  } buzz_cmd_t;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  poll_t cfg_wdata;
  logic  hold_off;

  bes_in_if  in_ch ();
  bes_out_if out_ch ();

  buzzer_effect_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // stimulus and expectation stores
  buzz_cmd_t buzz_q[$];
  res_t      timer_settings_q[$];
  int        items_made = 0;
  int        items_sent = 0;
  int        fail_cnt   = 0;
  int        send_gap   = 0;
  int        stall_left = 0;
  bit        gaps_on    = 1'b1;

  // predicted sequencer state
  int unsigned poll_iv   = POLL_RESET;
  effect_t     want_eff  = EFF_OFF;
  effect_t     cur_eff   = EFF_OFF;
  int          note_idx  = 0;
  int          ms_left   = 0;
  int unsigned poll_cnt  = 0;
  tone_t       tone      = TONE_P;
  logic        pwm       = 1'b0;
  logic        seq_on    = 1'b0;
  logic [15:0] finished_fx = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // note list of every effect; returns 0 past the end or for an unknown code
  function automatic bit tune_note(input effect_t fx, input int idx,
                                   output tone_t nt, output int ms);
    nt = TONE_P;
    ms = 0;
    case (fx)
      EFF_START: begin
        if (idx < 12) begin
          if (idx % 2 == 1) begin
            ms = 50;
          end else begin
            ms = 200;
            case (idx / 2)
              0:       nt = TONE_M1;
              1, 3:    nt = TONE_M2;
              2:       nt = TONE_M3;
              4:       nt = TONE_M5;
              default: nt = TONE_M7;
            endcase
          end
        end else if (idx == 12) begin
          nt = TONE_M6;
          ms = 500;
        end else if (idx == 13) begin
          nt = TONE_M5;
          ms = 250;
        end else if (idx == 14) begin
          nt = TONE_M6;
          ms = 750;
        end
      end
      EFF_CAP_ON, EFF_CAP_OFF, EFF_AIM_OFF: begin
        if (idx < 3) begin
          ms = 200;
          case (idx)
            0:       nt = (fx == EFF_CAP_ON) ? TONE_M1 : (fx == EFF_CAP_OFF) ? TONE_M5 : TONE_M7;
            1:       nt = (fx == EFF_AIM_OFF) ? TONE_M5 : TONE_M3;
            default: nt = (fx == EFF_CAP_ON) ? TONE_M5 : (fx == EFF_CAP_OFF) ? TONE_M1 : TONE_M3;
          endcase
        end
      end
      EFF_AIM_ON: begin
        if (idx < 6) begin
          nt = (idx % 2 == 1) ? TONE_P : TONE_M7;
          ms = (idx % 2 == 1) ? 150 : 50;
        end
      end
      default: begin
        // shots: note and pause pairs
        if (fx >= EFF_SHOOT1 && fx <= EFF_SHOOT8 && idx < 2 * (int'(fx) - 5)) begin
          nt = (idx % 2 == 1) ? TONE_P : TONE_M5;
          ms = 100;
        end
      end
    endcase
    return ms != 0;
  endfunction

  function automatic int unsigned tone_period(input tone_t t);
    if (t == TONE_P || t > TONE_TOP) return PAUSE_PERIOD;
    return TIMER_HZ / NOTE_HZ[t];
  endfunction

  // update the predicted state for one accepted transaction and queue its timer settings
  task automatic advance_buzzer(input logic act, input effect_t fx);
    tone_t       nt;
    int          nms;
    int unsigned cnt;
    res_t        r;
    if (act == ACT_REQUEST) begin
      // requests only land while no effect plays
      if (!seq_on) want_eff = fx;
    end else if (seq_on) begin
      if (ms_left > 0) ms_left--;
      if (ms_left == 0) begin
        note_idx++;
        if (tune_note(cur_eff, note_idx, nt, nms)) begin
          tone    = nt;
          ms_left = nms;
        end else begin
          seq_on = 1'b0;
          want_eff = EFF_OFF;
          poll_cnt = 0;
          finished_fx[cur_eff] = 1'b1;
        end
      end
    end else if (poll_cnt + 1 >= poll_iv) begin
      // poll of the pending request; unknown codes leave everything but the poll count as it is
      poll_cnt = 0;
      if (want_eff == EFF_OFF) begin
        tone = TONE_P;
        pwm  = 1'b0;
      end else if (tune_note(want_eff, 0, nt, nms)) begin
        cur_eff  = want_eff;
        note_idx = 0;
        tone     = nt;
        ms_left  = nms;
        pwm      = 1'b1;
        seq_on   = 1'b1;
      end
    end else begin
      poll_cnt++;
    end
    cnt = tone_period(tone);
    r.pwm_on        = pwm;
    r.reload_value  = reload_t'(cnt - 1);
    r.compare_value = compare_t'(cnt / 2);
    r.tone_now      = tone;
    r.playing       = seq_on;
    timer_settings_q.push_back(r);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string fld, input logic [15:0] want, input logic [15:0] got);
    $display("%0t mismatch %s: expected %0d, actual %0d", $time, fld, want, got);
    fail_cnt++;
  endtask

  // driver: offers queued transactions, predicts on every accepted one
  always @(posedge clk) begin : drive
    buzz_cmd_t cmd;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_buzzer(in_ch.action, in_ch.effect);
        items_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (buzz_q.size() > 0) begin
          cmd = buzz_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.action <= cmd.action;
          in_ch.effect <= cmd.effect;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin : watch
    logic took;
    res_t want;
    took = out_ch.valid && out_ch.ready;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (took) begin
        if (timer_settings_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual tone %0d", $time,
                   out_ch.tone_now);
          fail_cnt++;
        end else begin
          want = timer_settings_q.pop_front();
          if (out_ch.pwm_on !== want.pwm_on)
            report("pwm_on", want.pwm_on, out_ch.pwm_on);
          if (out_ch.reload_value !== want.reload_value)
            report("reload_value", want.reload_value, out_ch.reload_value);
          if (out_ch.compare_value !== want.compare_value)
            report("compare_value", want.compare_value, out_ch.compare_value);
          if (out_ch.tone_now !== want.tone_now)
            report("tone_now", want.tone_now, out_ch.tone_now);
          if (out_ch.playing !== want.playing)
            report("playing", want.playing, out_ch.playing);
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (took) stall_left = pick_gap();
      end
    end
  end

  // long receiver hold-off so the result buffer fills and input stalls
  initial begin
    wait (items_sent >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL buzzer_effect_sequencer_top");
    $finish;
  end

  task automatic push_item(input logic act, input effect_t fx);
    buzz_cmd_t cmd;
    cmd.action = act;
    cmd.effect = fx;
    buzz_q.push_back(cmd);
    items_made++;
  endtask

  // wait until every transaction is accepted and every result checked
  task automatic settle();
    do @(posedge clk);
    while (items_sent != items_made || timer_settings_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_poll(input int unsigned v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= poll_t'(v);
    @(posedge clk);
    cfg_we  <= 1'b0;
    poll_iv = v;
  endtask

  // effect choice; when chasing, favour effects not yet played to the end
  function automatic effect_t pick_effect(input bit chase);
    effect_t missing[$];
    int      r;
    if (chase && $urandom_range(0, 1) == 1) begin
      for (int e = EFF_START; e <= EFF_SHOOT8; e++)
        if (!finished_fx[e]) missing.push_back(effect_t'(e));
      if (missing.size() > 0) return missing[$urandom_range(0, missing.size() - 1)];
    end
    r = $urandom_range(0, 99);
    if (r < 8) return EFF_OFF;
    if (r < 14) return effect_t'($urandom_range(EFF_UNKNOWN_LO, EFF_UNKNOWN_HI));
    if (r < 18) return EFF_START;
    return effect_t'($urandom_range(EFF_CAP_ON, EFF_SHOOT8));
  endfunction

  // one request, at times after a random one, then ticks to poll, play it out and poll again unless cut short
  task automatic add_episode(input int pe, input effect_t fx);
    tone_t nt;
    int    ms;
    int    span;
    int    n;
    int    k;
    if ($urandom_range(0, 7) == 0)
      push_item(ACT_REQUEST, effect_t'($urandom_range(0, 15)));
    push_item(ACT_REQUEST, fx);
    span = 0;
    k = 0;
    while (tune_note(fx, k, nt, ms)) begin
      span += ms;
      k++;
    end
    n = pe + span + $urandom_range(0, 2 * pe);
    // some sequences cut short
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
    // long effects are cut off part way through
    if (n > EPISODE_MAX) n = $urandom_range(pe, EPISODE_MAX);
    for (k = 0; k < n; k++) begin
      // stray requests while the effect plays are lost
      if (k > pe && k < span && $urandom_range(0, 39) == 0)
        push_item(ACT_REQUEST, effect_t'($urandom_range(0, 15)));
      push_item(ACT_TICK, effect_t'($urandom_range(0, 15)));
    end
    while (buzz_q.size() > 64) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned poll, input int target, input bit chase);
    int first;
    int pe;
    first = items_made;
    pe = (poll == 0) ? 1 : poll;
    do add_episode(pe, pick_effect(chase));
    while (items_made - first < target);
  endtask

  // main sequence
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = POLL_RESET;
    hold_off     = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.effect = EFF_OFF;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: poll on every tick
    write_poll(1);
    push_item(ACT_TICK, EFF_OFF);            // poll with nothing pending
    push_item(ACT_REQUEST, EFF_UNKNOWN_HI);  // unknown code stays pending
    push_item(ACT_TICK, EFF_UNKNOWN_HI);
    push_item(ACT_REQUEST, EFF_UNKNOWN_LO);
    push_item(ACT_TICK, EFF_OFF);
    push_item(ACT_REQUEST, EFF_OFF);
    push_item(ACT_TICK, EFF_UNKNOWN_HI);
    push_item(ACT_REQUEST, EFF_SHOOT8);      // overwritten before the poll
    push_item(ACT_REQUEST, EFF_SHOOT1);
    push_item(ACT_TICK, EFF_OFF);            // shot starts
    push_item(ACT_REQUEST, EFF_START);       // lost while playing
    push_item(ACT_TICK, EFF_UNKNOWN_HI);
    push_item(ACT_REQUEST, EFF_AIM_OFF);     // lost while playing
    push_item(ACT_TICK, EFF_OFF);
    push_item(ACT_TICK, EFF_UNKNOWN_HI);

    // random phases across poll intervals
    run_phase(1, 250, 1'b0);
    write_poll(0);
    gaps_on = 1'b0;
    run_phase(0, 200, 1'b0);
    gaps_on = 1'b1;
    write_poll($urandom_range(2, 40));
    run_phase(poll_iv, 250, 1'b0);
    // long interval: the count climbs well past the next, shorter interval
    write_poll(1000);
    push_item(ACT_REQUEST, EFF_SHOOT1);
    for (int k = 0; k < 200; k++) push_item(ACT_TICK, EFF_OFF);
    write_poll(POLL_RESET);
    run_phase(POLL_RESET, 150, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS buzzer_effect_sequencer_top");
    end else begin
      $display("FAIL buzzer_effect_sequencer_top");
    end
    $finish;
  end

endmodule
